### rtl/fixed_timestep_frame_timer_defines.svh
// assertion macros used by the frame timer sequencer rtl
`ifndef FIXED_TIMESTEP_FRAME_TIMER_DEFINES_SVH
`define FIXED_TIMESTEP_FRAME_TIMER_DEFINES_SVH
`ifndef SYNTHESIS
// property must hold at every rising edge outside reset
`define FSFT_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("fsft assertion failed");
// expression must never be true outside reset
`define FSFT_ASSERT_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("fsft forbidden condition seen");
`else
`define FSFT_ASSERT(name, clk, rst, prop)
`define FSFT_ASSERT_NEVER(name, clk, rst, expr)
`endif
`endif

### rtl/fsft_pkg.sv
package fsft_pkg;

   localparam int SAMPLE_W   = 64;
   localparam int LONG_CFG_W = 40;
   localparam int FREQ_W     = 32;
   localparam int COUNT_W    = 32;
   localparam int TPS_W      = 24;
   localparam int MUL_HALF_W = LONG_CFG_W / 2;
   localparam int MUL_P_W    = MUL_HALF_W + TPS_W;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 40;
   localparam int RSP_W      = 2 * SAMPLE_W + 3 * COUNT_W;

   localparam int unsigned SNAP_DIVISOR = 4000;

   // request kinds
   localparam logic REQ_UPDATE = 1'b0;
   localparam logic REQ_RESET  = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_USE_FIXED = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET    = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DELTA = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ      = 8'd3;

   // register reset values
   localparam logic [LONG_CFG_W-1:0] TARGET_RESET    = 40'd166666;
   localparam logic [LONG_CFG_W-1:0] MAX_DELTA_RESET = 40'd1000000;
   localparam logic [FREQ_W-1:0]     FREQ_RESET      = 32'd10000000;

   typedef enum logic [1:0] {
      DIV_SEL_TICKS = 2'd0,
      DIV_SEL_STEPS = 2'd1,
      DIV_SEL_ACC   = 2'd2
   } div_sel_type;

   typedef struct packed {
      logic        capture;
      logic        clamp;
      logic        mul_lo;
      logic        mul_hi;
      logic        div_start;
      div_sel_type div_sel;
      logic        take_ticks;
      logic        var_update;
      logic        snap_sum;
      logic        hold_left;
      logic        take_steps;
      logic        fix_add;
      logic        latch_rate;
      logic        take_acc;
      logic        emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic use_fixed;
      logic target_zero;
      logic div_busy;
      logic div_done;
      logic quot_zero;
      logic acc_ge_freq;
   } dp_sts_type;

endpackage

### rtl/fixed_timestep_frame_timer.sv
// channel   dir   handshake               payload
// req       in    req_tvalid/req_tready   tdata counter_value, tuser req_type
// rsp       out   rsp_tvalid/rsp_tready   tdata elapsed, total, frames, fps, steps
// csr       in    csr_valid/csr_ready     csr_index, csr_data
//
// an update request runs one divide in variable mode and two in fixed mode (one if the target
// is zero), plus one more when a counter second completes, all on the shared divider (ticks,
// whole steps, second remainder); a reset request goes straight to the response load
// reset is synchronous and active high; it loads register defaults, clears timer state
// a held response stalls only the final load; the next request is taken meanwhile
module fixed_timestep_frame_timer #(
   parameter int unsigned TICKS_PER_SECOND = 10000000
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [fsft_pkg::SAMPLE_W-1:0]     req_tdata,  // [63:0] counter_value
   input  logic                              req_tuser,  // [0] req_type
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [63:0] elapsed_ticks, [127:64] total_ticks, [159:128] frame_count,
   // [191:160] frames_per_second, [223:192] steps_taken
   output logic [fsft_pkg::RSP_W-1:0]        rsp_tdata,
   // register write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fsft_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fsft_pkg::CSR_DATA_W-1:0]   csr_data
);

   fsft_pkg::ctrl_cmd_type cmd;
   fsft_pkg::dp_sts_type   sts;

   // registers must only change between requests; the block does not enforce this, so writes are always taken
   assign csr_ready = 1'b1;

   // sequencer: one request at a time through clamp, multiply and divides
   fsft_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tuser (req_tuser),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // timer state, config registers, multiplier, divider and response register
   fsft_dp #(
      .TICKS_PER_SECOND(TICKS_PER_SECOND)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_type  (req_tuser),
      .req_sample(req_tdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_tdata)
   );

endmodule

### rtl/fsft_div.sv
module fsft_div #(
   parameter int DIV_W = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             busy,
   output logic             done,
   output logic [DIV_W-1:0] quotient,
   output logic [DIV_W-1:0] remainder
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] den_ff, den_in;
   logic [DIV_W:0]   trial;
   logic [DIV_W:0]   trial_sub;
   logic             fits;

   // one quotient bit per cycle, restoring form
   assign trial     = {rem_ff, quo_ff[DIV_W-1]};
   assign trial_sub = trial - {1'b0, den_ff};
   assign fits      = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(DIV_W);
         rem_in   = '0;
         quo_in   = dividend;
         den_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
         quo_in   = {quo_ff[DIV_W-2:0], fits};
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

### rtl/fsft_ctrl.sv
`include "fixed_timestep_frame_timer_defines.svh"

module fsft_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tuser,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  fsft_pkg::dp_sts_type  sts,
   output fsft_pkg::ctrl_cmd_type cmd
);

   typedef enum logic [14:0] {
      S_IDLE       = 15'b000000000000001,
      S_CLAMP      = 15'b000000000000010,
      S_MUL_LO     = 15'b000000000000100,
      S_MUL_HI     = 15'b000000000001000,
      S_DIV_TICKS  = 15'b000000000010000,
      S_WAIT_TICKS = 15'b000000000100000,
      S_VAR        = 15'b000000001000000,
      S_SNAP       = 15'b000000010000000,
      S_HOLD       = 15'b000000100000000,
      S_DIV_STEPS  = 15'b000001000000000,
      S_WAIT_STEPS = 15'b000010000000000,
      S_FIX_ADD    = 15'b000100000000000,
      S_ACC_CHECK  = 15'b001000000000000,
      S_WAIT_ACC   = 15'b010000000000000,
      S_EMIT       = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = (req_tuser == fsft_pkg::REQ_RESET) ? S_EMIT : S_CLAMP;
            end
         end
         S_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = S_MUL_LO;
         end
         S_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_MUL_HI;
         end
         S_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_DIV_TICKS;
         end
         S_DIV_TICKS: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = fsft_pkg::DIV_SEL_TICKS;
            state_in      = S_WAIT_TICKS;
         end
         S_WAIT_TICKS: begin
            if (sts.div_done) begin
               cmd.take_ticks = 1'b1;
               state_in       = sts.use_fixed ? S_SNAP : S_VAR;
            end
         end
         S_VAR: begin
            cmd.var_update = 1'b1;
            state_in       = S_ACC_CHECK;
         end
         S_SNAP: begin
            cmd.snap_sum = 1'b1;
            state_in     = sts.target_zero ? S_HOLD : S_DIV_STEPS;
         end
         S_HOLD: begin
            cmd.hold_left = 1'b1;
            state_in      = S_ACC_CHECK;
         end
         S_DIV_STEPS: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = fsft_pkg::DIV_SEL_STEPS;
            state_in      = S_WAIT_STEPS;
         end
         S_WAIT_STEPS: begin
            if (sts.div_done) begin
               cmd.take_steps = 1'b1;
               state_in       = sts.quot_zero ? S_ACC_CHECK : S_FIX_ADD;
            end
         end
         S_FIX_ADD: begin
            cmd.fix_add = 1'b1;
            state_in    = S_ACC_CHECK;
         end
         S_ACC_CHECK: begin
            if (sts.acc_ge_freq) begin
               cmd.latch_rate = 1'b1;
               cmd.div_start  = 1'b1;
               cmd.div_sel    = fsft_pkg::DIV_SEL_ACC;
               state_in       = S_WAIT_ACC;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_WAIT_ACC: begin
            if (sts.div_done) begin
               cmd.take_acc = 1'b1;
               state_in     = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   `FSFT_ASSERT(a_accept_leaves_idle, clock, reset, (req_tvalid && req_tready) |=> (state_ff != S_IDLE))
   `FSFT_ASSERT(a_start_divider_free, clock, reset, cmd.div_start |-> !sts.div_busy)
   `FSFT_ASSERT(a_emit_output_free, clock, reset, cmd.emit |-> (!rsp_valid_ff || rsp_tready))
   `FSFT_ASSERT_NEVER(a_done_while_not_waiting, clock, reset, sts.div_done && (state_ff != S_WAIT_TICKS) && (state_ff != S_WAIT_STEPS) && (state_ff != S_WAIT_ACC))

endmodule

### rtl/fsft_dp.sv
module fsft_dp #(
   parameter int unsigned TICKS_PER_SECOND = 10000000
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [fsft_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fsft_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                                req_type,
   input  logic [fsft_pkg::SAMPLE_W-1:0]       req_sample,
   input  fsft_pkg::ctrl_cmd_type              cmd,
   output fsft_pkg::dp_sts_type                sts,
   output logic [fsft_pkg::RSP_W-1:0]          rsp_data
);

   localparam int W  = fsft_pkg::SAMPLE_W;
   localparam int LW = fsft_pkg::LONG_CFG_W;
   localparam int FW = fsft_pkg::FREQ_W;
   localparam int CW = fsft_pkg::COUNT_W;
   localparam int HW = fsft_pkg::MUL_HALF_W;
   localparam int PW = fsft_pkg::MUL_P_W;
   localparam logic [fsft_pkg::TPS_W-1:0] TPS = fsft_pkg::TPS_W'(TICKS_PER_SECOND);
   localparam logic [W-1:0] SNAP_LIMIT =
      W'(TICKS_PER_SECOND / fsft_pkg::SNAP_DIVISOR);

   // configuration
   logic          use_fixed_ff;
   logic [LW-1:0] target_ff;
   logic [LW-1:0] max_delta_ff;
   logic [FW-1:0] freq_ff;
   logic [FW-1:0] freq_eff;

   // timer state
   logic [W-1:0]  prev_ff, acc_ff, left_ff, last_ff, total_ff;
   logic [CW-1:0] frames_ff, fts_ff, rate_ff;

   // per-request scratch
   logic [W-1:0]  raw_ff, ticks_ff, sum_ff, steps_ff;
   logic [LW-1:0] delta_ff;
   logic [PW-1:0] prod_lo_ff, prod_hi_ff;
   logic [fsft_pkg::RSP_W-1:0] rsp_ff;

   logic [HW-1:0] mul_a;
   logic [PW-1:0] mul_p;
   logic [W-1:0]  product;
   logic [W-1:0]  target_w;
   logic [W-1:0]  div_dividend, div_divisor, div_quot, div_rem;
   logic          div_start, div_busy, div_done;
   logic [W:0]    quot_plus, target_plus, left_sum;
   logic          near;
   logic [CW-1:0] steps_sat;

   assign freq_eff = (freq_ff == '0) ? FW'(1) : freq_ff;
   assign target_w = W'(target_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         use_fixed_ff <= 1'b0;
         target_ff    <= fsft_pkg::TARGET_RESET;
         max_delta_ff <= fsft_pkg::MAX_DELTA_RESET;
         freq_ff      <= fsft_pkg::FREQ_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            fsft_pkg::CSR_USE_FIXED: use_fixed_ff <= csr_data[0];
            fsft_pkg::CSR_TARGET:    target_ff    <= csr_data;
            fsft_pkg::CSR_MAX_DELTA: max_delta_ff <= csr_data;
            fsft_pkg::CSR_FREQ:      freq_ff      <= csr_data[FW-1:0];
            default: ;
         endcase
      end
   end

   // shared 20 x 24 multiplier, two halves of the clamped delta
   assign mul_a   = cmd.mul_hi ? delta_ff[LW-1:HW] : delta_ff[HW-1:0];
   assign mul_p   = PW'(mul_a) * PW'(TPS);
   assign product = W'(prod_lo_ff) + (W'(prod_hi_ff) << HW);

   always_comb begin
      case (cmd.div_sel)
         fsft_pkg::DIV_SEL_STEPS: begin
            div_dividend = sum_ff;
            div_divisor  = target_w;
         end
         fsft_pkg::DIV_SEL_ACC: begin
            div_dividend = acc_ff;
            div_divisor  = W'(freq_eff);
         end
         default: begin
            div_dividend = product;
            div_divisor  = W'(freq_eff);
         end
      endcase
   end

   assign div_start = cmd.div_start;

   fsft_div #(
      .DIV_W(W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quot),
      .remainder(div_rem)
   );

   // |ticks - target| < limit  <=>  ticks < target + limit and target < ticks + limit
   assign quot_plus   = {1'b0, div_quot} + {1'b0, SNAP_LIMIT};
   assign target_plus = {1'b0, target_w} + {1'b0, SNAP_LIMIT};
   assign near        = ({1'b0, target_w} < quot_plus) && ({1'b0, div_quot} < target_plus);
   assign left_sum    = {1'b0, left_ff} + {1'b0, ticks_ff};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         raw_ff   <= req_sample - prev_ff;
         steps_ff <= '0;
      end
      if (cmd.clamp) begin
         delta_ff <= (raw_ff > W'(max_delta_ff)) ? max_delta_ff : raw_ff[LW-1:0];
      end
      if (cmd.mul_lo) begin
         prod_lo_ff <= mul_p;
      end
      if (cmd.mul_hi) begin
         prod_hi_ff <= mul_p;
      end
      if (cmd.take_ticks) begin
         ticks_ff <= (use_fixed_ff && near) ? target_w : div_quot;
      end
      if (cmd.snap_sum) begin
         // saturate on carry out
         sum_ff <= left_sum[W] ? '1 : left_sum[W-1:0];
      end else if (cmd.take_steps) begin
         sum_ff <= sum_ff - div_rem;
      end
      if (cmd.take_steps) begin
         steps_ff <= div_quot;
      end else if (cmd.var_update) begin
         steps_ff <= W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= '0;
         acc_ff    <= '0;
         left_ff   <= '0;
         last_ff   <= '0;
         total_ff  <= '0;
         frames_ff <= '0;
         fts_ff    <= '0;
         rate_ff   <= '0;
      end else begin
         if (cmd.capture) begin
            prev_ff <= req_sample;
            if (req_type == fsft_pkg::REQ_RESET) begin
               acc_ff  <= '0;
               left_ff <= '0;
               fts_ff  <= '0;
               rate_ff <= '0;
            end
         end
         if (cmd.clamp) begin
            acc_ff <= acc_ff + raw_ff;
         end else if (cmd.take_acc) begin
            acc_ff <= div_rem;
         end
         if (cmd.var_update) begin
            last_ff   <= ticks_ff;
            total_ff  <= total_ff + ticks_ff;
            left_ff   <= '0;
            frames_ff <= frames_ff + CW'(1);
            fts_ff    <= fts_ff + CW'(1);
         end
         if (cmd.hold_left) begin
            left_ff <= sum_ff;
         end
         if (cmd.take_steps) begin
            left_ff <= div_rem;
         end
         if (cmd.fix_add) begin
            last_ff   <= target_w;
            total_ff  <= total_ff + sum_ff;
            frames_ff <= frames_ff + steps_ff[CW-1:0];
            fts_ff    <= fts_ff + CW'(1);
         end
         if (cmd.latch_rate) begin
            rate_ff <= fts_ff;
            fts_ff  <= '0;
         end
      end
   end

   assign steps_sat = (steps_ff[W-1:CW] != '0) ? '1 : steps_ff[CW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff <= {steps_sat, rate_ff, frames_ff, total_ff, last_ff};
      end
   end

   assign rsp_data = rsp_ff;

   assign sts.use_fixed   = use_fixed_ff;
   assign sts.target_zero = (target_ff == '0);
   assign sts.div_busy    = div_busy;
   assign sts.div_done    = div_done;
   assign sts.quot_zero   = (div_quot == '0);
   assign sts.acc_ge_freq = (acc_ff >= W'(freq_eff));

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

typedef struct packed {
   logic [31:0] steps;
   logic [31:0] fps;
   logic [31:0] frames;
   logic [63:0] total;
   logic [63:0] elapsed;
} frame_result_type;

class frame_timer_scoreboard;
   logic [63:0] tick_rate;
   bit          fixed_mode;
   logic [39:0] step_len;
   logic [39:0] delta_limit;
   logic [31:0] count_rate;
   logic [63:0] last_count;
   logic [63:0] second_count;
   logic [63:0] leftover;
   logic [63:0] last_frame;
   logic [63:0] tick_sum;
   logic [31:0] frame_sum;
   logic [31:0] frames_in_second;
   logic [31:0] rate_latch;
   frame_result_type expected_q[$];
   int mismatches;

   function new(logic [63:0] tps);
      tick_rate = tps;
      fixed_mode = 1'b0;
      step_len = fsft_pkg::TARGET_RESET;
      delta_limit = fsft_pkg::MAX_DELTA_RESET;
      count_rate = fsft_pkg::FREQ_RESET;
      last_count = '0;
      second_count = '0;
      leftover = '0;
      last_frame = '0;
      tick_sum = '0;
      frame_sum = '0;
      frames_in_second = '0;
      rate_latch = '0;
      mismatches = 0;
   endfunction

   function void set_reg(logic [fsft_pkg::CSR_IDX_W-1:0] idx,
                         logic [fsft_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         fsft_pkg::CSR_USE_FIXED: fixed_mode = data[0];
         fsft_pkg::CSR_TARGET:    step_len = data;
         fsft_pkg::CSR_MAX_DELTA: delta_limit = data;
         fsft_pkg::CSR_FREQ:      count_rate = data[31:0];
         default: ;
      endcase
   endfunction

   // advance the timer state by one accepted request and queue its response
   function void note_request(logic kind, logic [63:0] count_in);
      logic [63:0] rate;
      logic [63:0] delta;
      logic [63:0] ticks;
      logic [63:0] target;
      logic [63:0] gap_to_target;
      logic [63:0] sum;
      logic [63:0] steps;
      frame_result_type r;
      rate = (count_rate == 0) ? 64'd1 : {32'd0, count_rate};
      steps = '0;
      if (kind == fsft_pkg::REQ_RESET) begin
         last_count = count_in;
         leftover = '0;
         rate_latch = '0;
         frames_in_second = '0;
         second_count = '0;
      end else begin
         delta = count_in - last_count;
         last_count = count_in;
         second_count = second_count + delta;
         if (delta > {24'd0, delta_limit})
            delta = {24'd0, delta_limit};
         ticks = (delta * tick_rate) / rate;
         if (fixed_mode) begin
            target = {24'd0, step_len};
            gap_to_target = (ticks > target) ? ticks - target : target - ticks;
            if (gap_to_target < tick_rate / fsft_pkg::SNAP_DIVISOR)
               ticks = target;
            sum = leftover + ticks;
            if (sum < leftover)
               sum = '1;
            if (target != 0) begin
               steps = sum / target;
               sum = sum % target;
               if (steps != 0) begin
                  last_frame = target;
                  tick_sum = tick_sum + steps * target;
                  frame_sum = frame_sum + steps[31:0];
               end
            end
            leftover = sum;
         end else begin
            last_frame = ticks;
            tick_sum = tick_sum + ticks;
            leftover = '0;
            frame_sum = frame_sum + 1;
            steps = 64'd1;
         end
         if (steps != 0)
            frames_in_second = frames_in_second + 1;
         if (second_count >= rate) begin
            rate_latch = frames_in_second;
            frames_in_second = '0;
            second_count = second_count % rate;
         end
      end
      r.elapsed = last_frame;
      r.total = tick_sum;
      r.frames = frame_sum;
      r.fps = rate_latch;
      r.steps = (steps > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : steps[31:0];
      expected_q.push_back(r);
   endfunction

   task report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      if (mismatches < 40)
         $display("mismatch %s: got %0h, expected %0h", field, got, want);
      mismatches++;
   endtask

   task check_response(logic [fsft_pkg::RSP_W-1:0] data);
      frame_result_type got;
      frame_result_type want;
      got = data;
      if (expected_q.size() == 0) begin
         report_mismatch("response with no request pending", '0, '0);
         return;
      end
      want = expected_q.pop_front();
      if (got.elapsed !== want.elapsed) report_mismatch("elapsed_ticks", got.elapsed, want.elapsed);
      if (got.total !== want.total) report_mismatch("total_ticks", got.total, want.total);
      if (got.frames !== want.frames) report_mismatch("frame_count", got.frames, want.frames);
      if (got.fps !== want.fps) report_mismatch("frames_per_second", got.fps, want.fps);
      if (got.steps !== want.steps) report_mismatch("steps_taken", got.steps, want.steps);
   endtask
endclass

module tb;
   import fsft_pkg::*;

   localparam int unsigned TICKS_PER_SECOND = 10000000;
   // several times the slowest gap between handshakes, the worst update included
   localparam int WATCHDOG_LIMIT = 2000;
   // quiet time after the last response, to catch anything extra
   localparam int TAIL_CYCLES = 300;
   localparam logic [39:0] MAX40 = 40'hFF_FFFF_FFFF;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [SAMPLE_W-1:0]   req_tdata = '0;   // [63:0] counter_value
   logic                  req_tuser = 1'b0; // [0] req_type
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [63:0] elapsed, [127:64] total, [159:128] frames, [191:160] fps, [223:192] steps
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   frame_timer_scoreboard sb;
   logic [63:0] counter_now;  // last counter value sent
   bit          steady_flow;  // when set, neither side idles
   int          quiet_cycles;

   fixed_timestep_frame_timer #(
      .TICKS_PER_SECOND(TICKS_PER_SECOND)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // response checking, sampled before this edge's updates land
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata);
   end

   // watchdog: any handshake resets the quiet counter
   initial quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // response side: random stall before each response, none in steady stretches
   initial begin : rsp_side
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // one request; valid stays up across back-to-back requests
   task send_request(input logic kind, input logic [63:0] value);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= value;
      do @(posedge clock); while (!req_tready);
      sb.note_request(kind, value);
   endtask

   task send_delta(input logic [63:0] delta);
      counter_now = counter_now + delta;
      send_request(REQ_UPDATE, counter_now);
   endtask

   task send_rebase(input logic [63:0] value);
      counter_now = value;
      send_request(REQ_RESET, value);
   endtask

   // sender holds off until every pending response is back
   task drain_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.expected_q.size() != 0);
   endtask

   // register writes only happen with the timer idle
   task write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      drain_responses();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task set_config(input logic fixed, input logic [39:0] target, input logic [39:0] max_delta,
                   input logic [31:0] freq);
      write_reg(CSR_USE_FIXED, {39'd0, fixed});
      write_reg(CSR_TARGET, target);
      write_reg(CSR_MAX_DELTA, max_delta);
      write_reg(CSR_FREQ, {8'd0, freq});
   endtask

   // mostly frame-like counter steps around the target, plus clamps, jumps and rebases
   task run_phase(input int items);
      int          pick;
      logic [103:0] prod;
      logic [63:0] nominal;
      logic [63:0] span;
      logic [63:0] delta;
      for (int i = 0; i < items; i++) begin
         if (i % 40 == 0)
            steady_flow = ($urandom_range(0, 3) == 0);
         if (i > 0 && $urandom_range(0, 63) == 0)
            drain_responses();
         // counts that map onto one target step, and a window a bit wider than the snap band
         prod = sb.step_len;
         prod = prod * sb.count_rate;
         nominal = prod / TICKS_PER_SECOND;
         span = (64'd5000 * sb.count_rate) / TICKS_PER_SECOND + 64'd4;
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            if ($urandom_range(0, 1) == 1)
               send_rebase({$urandom, $urandom});
            else
               send_rebase(counter_now + $urandom_range(0, 100));
         end else if (pick < 90) begin
            if (pick < 50)
               delta = nominal + ({$urandom, $urandom} % (span + 1)) - (span >> 1);
            else if (pick < 64)
               delta = sb.count_rate / $urandom_range(20, 200);
            else if (pick < 74)
               delta = $urandom_range(0, 1000);
            else
               delta = {$urandom, $urandom} >> $urandom_range(0, 63);
            send_delta(delta);
         end else if (pick < 96) begin
            counter_now = {$urandom, $urandom};
            send_request(REQ_UPDATE, counter_now);
         end else begin
            send_delta(64'd0);
         end
      end
   endtask

   task random_config();
      logic [39:0] target;
      logic [39:0] max_delta;
      logic [31:0] freq;
      target = {$urandom, $urandom} >> $urandom_range(24, 63);
      if (target == 0)
         target = 40'd1;
      max_delta = {$urandom, $urandom} >> $urandom_range(24, 63);
      freq = $urandom >> $urandom_range(0, 31);
      if (freq == 0)
         freq = 32'd1;
      set_config($urandom_range(0, 1), target, max_delta, freq);
   endtask

   initial begin : stimulus
      int phase;
      sb = new(TICKS_PER_SECOND);
      counter_now = '0;
      steady_flow = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // variable step with reset defaults
      send_delta(64'd0);
      send_delta(64'd166666);
      send_delta(64'd1000005);                 // above the clamp
      send_rebase(64'hFFFF_FFFF_FFFF_FF00);
      counter_now = 64'h0000_0000_0000_0100;   // counter wraps past zero
      send_request(REQ_UPDATE, counter_now);
      counter_now = '1;
      send_request(REQ_UPDATE, counter_now);

      // fixed step around the snap band
      write_reg(CSR_USE_FIXED, 40'd1);
      send_delta(64'd166666 + 64'd2499);
      send_delta(64'd166666 - 64'd2499);
      send_delta(64'd166666 + 64'd2500);       // just outside the band
      send_delta(64'd0);                       // no step, leftover kept
      send_delta(64'd1000000);                 // several steps at once

      // zero target keeps everything in the leftover
      write_reg(CSR_TARGET, 40'd0);
      send_delta(64'd500000);

      // zero frequency acts as one; two maximal deltas saturate the leftover
      write_reg(CSR_MAX_DELTA, MAX40);
      write_reg(CSR_FREQ, 40'd0);
      send_delta({24'd0, MAX40});
      send_delta({24'd0, MAX40});

      // drain the saturated leftover with the widest step
      write_reg(CSR_TARGET, MAX40);
      send_delta(64'd0);

      // unit step: step count saturates, frame count wraps
      write_reg(CSR_TARGET, 40'd1);
      send_delta({24'd0, MAX40});
      send_rebase(64'd0);
      send_delta(64'd5);

      for (phase = 0; phase < 10; phase++) begin
         case (phase)
            0: set_config(1'b0, 40'd166666, 40'd1000000, 32'd10000000);
            1: set_config(1'b1, 40'd166666, 40'd1000000, 32'd10000000);
            2: set_config(1'b1, 40'd83333, 40'd1000000, 32'd10000000);
            3: set_config(1'b1, 40'd166666, 40'd4000000, 32'd24000000);
            4: set_config(1'b1, 40'd1, MAX40, 32'hFFFF_FFFF);
            5: set_config(1'b1, MAX40, MAX40, 32'd1);
            6: set_config(1'b0, 40'd166666, 40'd0, 32'd1);
            default: random_config();
         endcase
         run_phase(118);
      end

      steady_flow = 1'b0;
      drain_responses();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
